@@ rtl/core/arra_pkg.sv @@
// ----------------------------------------------------------------------------
// arra_pkg: shared types and constants for the aspect ratio approximator
// Holds the payload structs of both channels, the job passed from the
// front end to the back end, and the back end state encoding.
// ----------------------------------------------------------------------------
package arra_pkg;

  // Fixed field widths
  localparam int IN_W          = 16;
  localparam int TERM_W        = 24;
  localparam int CFG_W         = 8;
  localparam int SIDE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_W-1:0] MAX_DEN_RESET = 8'd10;

  // One input item
  typedef struct packed {
    logic [IN_W-1:0] width;
    logic [IN_W-1:0] height;
  } item_t;

  // One result item
  typedef struct packed {
    logic              valid_res;
    logic [TERM_W-1:0] width_term;
    logic [TERM_W-1:0] height_term;
  } res_t;

  // Classified job: larger side over smaller side
  typedef struct packed {
    logic            zero_side;
    logic            width_major;
    logic [IN_W-1:0] num;
    logic [IN_W-1:0] den;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_OUT
  } back_state_t;

endpackage

@@ rtl/core/arra_front.sv @@
// ----------------------------------------------------------------------------
// arra_front: input classifier
// Takes input transfers while the job queue has room, masks the sides,
// flags a zero side and orders the sides as larger over smaller.
// ----------------------------------------------------------------------------
module arra_front #(
  parameter int SIDE_W = arra_pkg::SIDE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  arra_pkg::item_t item,
  input  logic            queue_full,
  output logic            push,
  output arra_pkg::job_t  job
);
  import arra_pkg::*;

  localparam logic [IN_W-1:0] SIDE_MASK = {IN_W{1'b1}} >> (IN_W - SIDE_W);

  logic [IN_W-1:0] w;
  logic [IN_W-1:0] h;

  // Mask sides to the configured side width
  assign w = item.width & SIDE_MASK;
  assign h = item.height & SIDE_MASK;

  // Hold the producer while the queue is full
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  // Classify: zero side, orientation, larger and smaller side
  always_comb begin
    job.zero_side   = (w == '0) || (h == '0);
    job.width_major = (w > h);
    job.num         = (w > h) ? w : h;
    job.den         = (w > h) ? h : w;
  end

  // A transfer is never taken into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !queue_full)
    else $error("front pushed into a full queue");

endmodule

@@ rtl/core/arra_queue.sv @@
// ----------------------------------------------------------------------------
// arra_queue: short job queue
// Decouples the front end from the back end so that each side can stall
// on its own. Circular buffer with read and write pointers and a count.
// ----------------------------------------------------------------------------
module arra_queue #(
  parameter int DEPTH = arra_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  arra_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output arra_pkg::job_t pop_data,
  output logic           empty
);
  import arra_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from an empty queue");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ rtl/core/arra_div.sv @@
// ----------------------------------------------------------------------------
// arra_div: restoring integer divider
// One quotient bit per cycle. A start pulse loads the operands; done
// pulses once quotient and remainder are ready, and they hold until the
// next start.
// ----------------------------------------------------------------------------
module arra_div #(
  parameter int SIDE_W = arra_pkg::SIDE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SIDE_W-1:0] dividend,
  input  logic [SIDE_W-1:0] divisor,
  output logic              done,
  output logic [SIDE_W-1:0] quo,
  output logic [SIDE_W-1:0] rem
);

  localparam int CNT_W = $clog2(SIDE_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SIDE_W-1:0] dq;
  logic [SIDE_W-1:0] rem_r;
  logic [SIDE_W-1:0] dvs;
  logic [SIDE_W:0]   trial;
  logic [SIDE_W:0]   diff;
  logic              fits;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_r, dq[SIDE_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  assign quo = dq;
  assign rem = rem_r;

  // Control: busy, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SIDE_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dq    <= dividend;
      rem_r <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      rem_r <= fits ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
      dq    <= {dq[SIDE_W-2:0], fits};
    end
  end

endmodule

@@ rtl/core/arra_back.sv @@
// ----------------------------------------------------------------------------
// arra_back: continued fraction engine
// Pops classified jobs, runs Euclid steps on its single divider and keeps
// the convergent matrix, stopping when the next denominator would exceed
// the limit or the remainder is zero. Drives the output register.
// ----------------------------------------------------------------------------
module arra_back #(
  parameter int SIDE_W = arra_pkg::SIDE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [arra_pkg::CFG_W-1:0] max_den,
  input  logic                       job_empty,
  output logic                       job_pop,
  input  arra_pkg::job_t             job,
  output logic                       res_valid,
  input  logic                       res_stall,
  output arra_pkg::res_t             res
);
  import arra_pkg::*;

  localparam int QP_W = CFG_W + SIDE_W;
  localparam int PP_W = TERM_W + SIDE_W;

  back_state_t       state;
  back_state_t       state_next;

  logic [SIDE_W-1:0] den_r;
  logic              wmaj;
  logic [TERM_W-1:0] p0;
  logic [TERM_W-1:0] p1;
  logic [CFG_W-1:0]  q0;
  logic [CFG_W-1:0]  q1;
  logic [QP_W-1:0]   qprod;
  logic [TERM_W-1:0] pprod;
  res_t              pend;
  res_t              pend_next;
  logic              out_free;

  logic              div_start;
  logic [SIDE_W-1:0] div_a;
  logic [SIDE_W-1:0] div_b;
  logic              div_done;
  logic [SIDE_W-1:0] quo;
  logic [SIDE_W-1:0] rem;

  logic [QP_W:0]           q_new;
  logic [TERM_W-1:0]       p_new;
  logic                    over_limit;
  logic                    stop;
  logic [TERM_W-1:0]       fin_p;
  logic [TERM_W-1:0]       fin_q;
  logic [TERM_W+SIDE_W-1:0] pprod_full;

  // Candidate convergent for this term
  assign q_new      = {1'b0, qprod} + (QP_W + 1)'(q1);
  assign p_new      = pprod + p1;
  assign over_limit = q_new > (QP_W + 1)'(max_den);
  assign stop       = over_limit || (rem == '0);
  assign fin_p      = over_limit ? p0 : p_new;
  assign fin_q      = over_limit ? TERM_W'(q0) : TERM_W'(q_new[CFG_W-1:0]);
  assign pprod_full = PP_W'(p0) * PP_W'(quo);
  assign out_free   = !res_valid || !res_stall;

  // Divider operands: fresh job, or shift down one Euclid step
  always_comb begin
    if (state == ST_IDLE) begin
      div_a = job.num[SIDE_W-1:0];
      div_b = job.den[SIDE_W-1:0];
    end else begin
      div_a = den_r;
      div_b = rem;
    end
  end

  arra_div #(
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  // Next state, pop, divider start and pending result
  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    div_start  = 1'b0;
    pend_next  = pend;
    case (state)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          if (job.zero_side) begin
            pend_next  = '0;
            state_next = ST_OUT;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (stop) begin
          pend_next.valid_res   = 1'b1;
          pend_next.width_term  = wmaj ? fin_p : fin_q;
          pend_next.height_term = wmaj ? fin_q : fin_p;
          state_next            = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Convergent matrix, products and the pending and output result
  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (state == ST_OUT && out_free) begin
      res <= pend;
    end
    case (state)
      ST_IDLE: begin
        den_r <= job.den[SIDE_W-1:0];
        wmaj  <= job.width_major;
        p0    <= TERM_W'(1);
        p1    <= '0;
        q0    <= '0;
        q1    <= CFG_W'(1);
      end
      ST_MUL: begin
        qprod <= QP_W'(q0) * QP_W'(quo);
        pprod <= pprod_full[TERM_W-1:0];
      end
      ST_UPD: begin
        if (!over_limit) begin
          p1 <= p0;
          p0 <= p_new;
          q1 <= q0;
          q0 <= q_new[CFG_W-1:0];
        end
        den_r <= rem;
      end
      default: begin
      end
    endcase
  end

  // Euclid never divides by zero
  assert property (@(posedge clk) disable iff (rst) div_start |-> div_b != '0)
    else $error("divider started with a zero divisor");

  // Kept denominator stays within the limit while a job runs
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_MUL || state == ST_UPD) |-> q0 <= max_den)
    else $error("convergent denominator above limit");

  // A new result only appears after the output state
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_OUT)
    else $error("result shown outside the output state");

endmodule

@@ rtl/core/aspect_ratio_rational_approx.sv @@
// ----------------------------------------------------------------------------
// aspect_ratio_rational_approx: small-integer aspect ratio of an image
// Finds the continued fraction convergent of larger side over smaller
// side whose denominator stays within max_denominator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid / item_stall / item carries width and height.
//   A transfer happens when item_valid is high and item_stall is low.
//   Output channel res_valid / res_stall / res returns one result per item:
//   valid_res, width_term and height_term in width:height order.
//   cfg_wen / cfg_wdata write max_denominator (reset value 10); write only
//   while no item is in flight.
// Term loop:
//   Each continued fraction term runs the bit-serial divider, then a
//   multiply state and an update state. A zero side skips the divider and
//   goes straight to the output state. With max_denominator at 255 an item
//   runs at most about 14 terms.
// Reset and stalls:
//   Synchronous reset empties the two-entry job queue, idles the engine and
//   drops the output. A stalled result holds in the output register while
//   the front end keeps taking items until the queue is full.
// ----------------------------------------------------------------------------
module aspect_ratio_rational_approx #(
  parameter int SIDE_BITS = arra_pkg::SIDE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  arra_pkg::item_t            item,
  output logic                       res_valid,
  input  logic                       res_stall,
  output arra_pkg::res_t             res,
  input  logic                       cfg_wen,
  input  logic [arra_pkg::CFG_W-1:0] cfg_wdata
);
  import arra_pkg::*;

  localparam int SIDE_W = (SIDE_BITS < IN_W) ? SIDE_BITS : IN_W;

  logic [CFG_W-1:0] max_den_r;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  job_t             push_job;
  job_t             pop_job;

  // Hold the denominator limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_den_r <= MAX_DEN_RESET;
    end else if (cfg_wen) begin
      max_den_r <= cfg_wdata;
    end
  end

  arra_front #(
    .SIDE_W (SIDE_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (q_full),
    .push       (push),
    .job        (push_job)
  );

  arra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_job),
    .empty     (q_empty)
  );

  arra_back #(
    .SIDE_W (SIDE_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_den   (max_den_r),
    .job_empty (q_empty),
    .job_pop   (pop),
    .job       (pop_job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
